// ===== rtl/core/billboard_quad_expander_core_assert.svh =====
// ----------------------------------------------------------------------------
// billboard quad expander assertion macros
// shared property wrappers, clocked on clock and disabled in reset
// ----------------------------------------------------------------------------
`ifndef BILLBOARD_QUAD_EXPANDER_CORE_ASSERT_SVH
`define BILLBOARD_QUAD_EXPANDER_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define BQE_ASSERT_IMPLY(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bqe assertion failed");
`define BQE_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bqe assertion failed");
`else
`define BQE_ASSERT_IMPLY(name, ante, cons)
`define BQE_ASSERT_NEXT(name, ante, cons)
`endif
`endif

// ===== rtl/core/bqe_pkg.sv =====
// ----------------------------------------------------------------------------
// bqe_pkg
// types, constants and helpers of the billboard quad expander
// ----------------------------------------------------------------------------
package bqe_pkg;

   localparam int ATLAS_MAX = 256;
   localparam int CELL_W  = 9;
   localparam int CELLS_W = 18;
   localparam int FRAME_W = 32;
   localparam int TEX_W   = 18;
   localparam int SCL_W   = 27;

   localparam logic [2:0] CSR_CAMERA_LEFT = 3'd0;
   localparam logic [2:0] CSR_CAMERA_UP   = 3'd1;
   localparam logic [2:0] CSR_ATLAS_COLS  = 3'd2;
   localparam logic [2:0] CSR_ATLAS_ROWS  = 3'd3;
   localparam logic [2:0] CSR_FRAME_RATE  = 3'd4;
   localparam logic [2:0] CSR_TINT_COLOR  = 3'd5;
   localparam logic [2:0] CSR_MODE_FLAGS  = 3'd6;

   localparam logic [16:0] SIN_A = 17'd102944;
   localparam logic [15:0] SIN_B = 16'd42048;
   localparam logic [12:0] SIN_C = 13'd4640;
   localparam logic [15:0] QUARTER_TURN = 16'd16384;

   localparam logic signed [TEX_W-1:0] TEX_ONE  = 18'sd65536;
   localparam logic signed [19:0]      TEX_HALF = 20'sd32768;

   typedef struct packed {
      logic signed [31:0]       pos_x;
      logic signed [31:0]       pos_y;
      logic signed [31:0]       pos_z;
      logic signed [SCL_W-1:0]  lv_x;
      logic signed [SCL_W-1:0]  lv_y;
      logic signed [SCL_W-1:0]  lv_z;
      logic signed [SCL_W-1:0]  uv_x;
      logic signed [SCL_W-1:0]  uv_y;
      logic signed [SCL_W-1:0]  uv_z;
      logic [15:0]              col_r;
      logic [15:0]              col_g;
      logic [15:0]              col_b;
      logic [15:0]              col_a;
      logic                     batch_end;
      logic signed [TEX_W-1:0]  tex_p;
      logic signed [TEX_W-1:0]  tex_q;
   } particle_type;

   typedef struct packed {
      particle_type             part;
      logic [3:0][TEX_W-1:0]    tex_u;
      logic [3:0][TEX_W-1:0]    tex_v;
   } vertex_type;

   function automatic logic [14:0] sine_arg(input logic [15:0] ang);
      logic [14:0] f;
      f = {1'b0, ang[13:0]};
      return ang[14] ? (15'd16384 - f) : f;
   endfunction

   function automatic logic signed [31:0] sat_pos(input logic signed [33:0] v);
      if (v > 34'sd2147483647) begin
         return 32'sh7FFFFFFF;
      end else if (v < -34'sd2147483648) begin
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

   function automatic logic [CELL_W-1:0] clamp_cells(input logic [CELL_W-1:0] v,
                                                      input logic [12:0] cmax);
      if (v == '0) begin
         return 9'd1;
      end else if ({4'b0, v} > cmax) begin
         return cmax[CELL_W-1:0];
      end
      return v;
   endfunction

endpackage

// ===== rtl/core/bqe_req_if.sv =====
// ----------------------------------------------------------------------------
// bqe_req_if
// particle item channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface bqe_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [31:0] pos_z;
   logic [15:0]        half_size;
   logic [31:0]        life_time;
   logic [15:0]        rotation;
   logic [15:0]        color_r;
   logic [15:0]        color_g;
   logic [15:0]        color_b;
   logic [15:0]        color_a;
   logic               batch_end;

   modport source (output valid, pos_x, pos_y, pos_z, half_size, life_time, rotation,
                   color_r, color_g, color_b, color_a, batch_end, input ready);
   modport sink   (input valid, pos_x, pos_y, pos_z, half_size, life_time, rotation,
                   color_r, color_g, color_b, color_a, batch_end, output ready);
endinterface

// ===== rtl/core/bqe_rsp_if.sv =====
// ----------------------------------------------------------------------------
// bqe_rsp_if
// vertex item channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface bqe_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] vert_x;
   logic signed [31:0] vert_y;
   logic signed [31:0] vert_z;
   logic signed [17:0] tex_u;
   logic signed [17:0] tex_v;
   logic [15:0]        out_r;
   logic [15:0]        out_g;
   logic [15:0]        out_b;
   logic [15:0]        out_a;
   logic               quad_last;
   logic               batch_done;

   modport source (output valid, vert_x, vert_y, vert_z, tex_u, tex_v, out_r, out_g,
                   out_b, out_a, quad_last, batch_done, input ready);
   modport sink   (input valid, vert_x, vert_y, vert_z, tex_u, tex_v, out_r, out_g,
                   out_b, out_a, quad_last, batch_done, output ready);
endinterface

// ===== rtl/core/billboard_quad_expander_core.sv =====
// ----------------------------------------------------------------------------
// billboard_quad_expander_core
// expands each particle item into four camera-facing corner vertices
// ----------------------------------------------------------------------------
// req carries one particle item per valid/ready handshake; rsp returns four
// vertex items per particle in the order (-L-U), (-L+U), (+L+U), (+L-U), the
// fourth flagged by quad_last. csr_we/csr_index/csr_wdata write the camera
// vectors, atlas size, frame rate, tint and mode; the user is to write them
// only between batches, the block itself does not enforce it. Between an
// accepted particle and its first vertex lie 5 front stages, 32 + 18 + 25
// divider stages for the atlas frame wrap, cell split and cell edges, one
// record stage and one output register. The pipeline takes a particle every
// cycle unless held; the vertex port emits one vertex per cycle while rsp is
// ready, so the four-vertex expander sets the sustained particle rate.
// Reset clears all valid bits and loads the register defaults. When rsp is
// stalled the output register and the held particle keep their values, and
// the whole pipeline holds once its last stage is full; req.ready then drops.
// ----------------------------------------------------------------------------
module billboard_quad_expander_core (
   input  logic         clock,
   input  logic         reset,
   bqe_req_if.sink      req,
   bqe_rsp_if.source    rsp,
   input  logic         csr_we,
   input  logic [2:0]   csr_index,
   input  logic [63:0]  csr_wdata
);

   localparam logic [12:0] CELL_MAX = 13'(bqe_pkg::ATLAS_MAX);
   localparam int CW  = bqe_pkg::CELL_W;
   localparam int NW  = bqe_pkg::CELLS_W;
   localparam int EW  = CW + 16;
   localparam int PW  = $bits(bqe_pkg::particle_type);

   logic [47:0]     camera_left_ff;
   logic [47:0]     camera_up_ff;
   logic [CW-1:0]   atlas_cols_ff;
   logic [CW-1:0]   atlas_rows_ff;
   logic [31:0]     frame_rate_ff;
   logic [63:0]     tint_color_ff;
   logic [1:0]      mode_flags_ff;
   logic [CW-1:0]   cols_ff;
   logic [CW-1:0]   rows_ff;
   logic [NW-1:0]   cells_ff;

   logic                  adv;
   logic                  take;
   logic                  f_valid;
   bqe_pkg::particle_type f_part;
   logic [31:0]           f_frame;
   logic                  a_valid;
   logic [0:0][31:0]      a_quo;
   logic [0:0][NW-1:0]    a_rem;
   bqe_pkg::particle_type a_part;
   logic                  b_valid;
   logic [0:0][NW-1:0]    b_quo;
   logic [0:0][CW-1:0]    b_rem;
   bqe_pkg::particle_type b_part;
   logic                  c_valid;
   logic [3:0][EW-1:0]    c_num;
   logic [3:0][CW-1:0]    c_den;
   logic [3:0][EW-1:0]    c_quo;
   logic [3:0][CW-1:0]    c_rem;
   bqe_pkg::particle_type c_part;
   bqe_pkg::vertex_type   vrec;
   logic [17:0]           u0, u1, vt, vb, tp, tq;

   always_ff @(posedge clock) begin
      if (reset) begin
         camera_left_ff <= '0;
         camera_up_ff   <= '0;
         atlas_cols_ff  <= 9'd1;
         atlas_rows_ff  <= 9'd1;
         frame_rate_ff  <= 32'd65536;
         tint_color_ff  <= '1;
         mode_flags_ff  <= 2'd0;
      end else if (csr_we) begin
         unique case (csr_index)
            bqe_pkg::CSR_CAMERA_LEFT: camera_left_ff <= csr_wdata[47:0];
            bqe_pkg::CSR_CAMERA_UP:   camera_up_ff   <= csr_wdata[47:0];
            bqe_pkg::CSR_ATLAS_COLS:  atlas_cols_ff  <= csr_wdata[CW-1:0];
            bqe_pkg::CSR_ATLAS_ROWS:  atlas_rows_ff  <= csr_wdata[CW-1:0];
            bqe_pkg::CSR_FRAME_RATE:  frame_rate_ff  <= csr_wdata[31:0];
            bqe_pkg::CSR_TINT_COLOR:  tint_color_ff  <= csr_wdata;
            bqe_pkg::CSR_MODE_FLAGS:  mode_flags_ff  <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   // clamped atlas size, settles well before an item reaches the dividers
   always_ff @(posedge clock) begin
      cols_ff  <= bqe_pkg::clamp_cells(atlas_cols_ff, CELL_MAX);
      rows_ff  <= bqe_pkg::clamp_cells(atlas_rows_ff, CELL_MAX);
      cells_ff <= cols_ff * rows_ff;
   end

   assign adv = !c_valid || take;

   bqe_front u_front (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .req         (req),
      .camera_left (camera_left_ff),
      .camera_up   (camera_up_ff),
      .frame_rate  (frame_rate_ff),
      .tint_color  (tint_color_ff),
      .mode_flags  (mode_flags_ff),
      .out_valid   (f_valid),
      .out_part    (f_part),
      .out_frame   (f_frame)
   );

   // frame wrap modulo columns*rows
   bqe_div_pipe #(.NW(32), .DW(NW), .LANES(1), .PW(PW)) u_div_wrap (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (f_valid),
      .num       (f_frame),
      .den       (cells_ff),
      .in_data   (f_part),
      .out_valid (a_valid),
      .quo       (a_quo),
      .rem       (a_rem),
      .out_data  (a_part)
   );

   // row and column of the cell
   bqe_div_pipe #(.NW(NW), .DW(CW), .LANES(1), .PW(PW)) u_div_cell (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (a_valid),
      .num       (a_rem),
      .den       (cols_ff),
      .in_data   (a_part),
      .out_valid (b_valid),
      .quo       (b_quo),
      .rem       (b_rem),
      .out_data  (b_part)
   );

   assign c_num[0] = {b_rem[0], 16'd0};
   assign c_num[1] = {b_rem[0] + 9'd1, 16'd0};
   assign c_num[2] = {b_quo[0][CW-1:0], 16'd0};
   assign c_num[3] = {b_quo[0][CW-1:0] + 9'd1, 16'd0};
   assign c_den[0] = cols_ff;
   assign c_den[1] = cols_ff;
   assign c_den[2] = rows_ff;
   assign c_den[3] = rows_ff;

   // cell edges in texture space
   bqe_div_pipe #(.NW(EW), .DW(CW), .LANES(4), .PW(PW)) u_div_edge (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (b_valid),
      .num       (c_num),
      .den       (c_den),
      .in_data   (b_part),
      .out_valid (c_valid),
      .quo       (c_quo),
      .rem       (c_rem),
      .out_data  (c_part)
   );

   always_comb begin
      u0 = {1'b0, c_quo[0][16:0]};
      u1 = {1'b0, c_quo[1][16:0]};
      vt = bqe_pkg::TEX_ONE - {1'b0, c_quo[2][16:0]};
      vb = bqe_pkg::TEX_ONE - {1'b0, c_quo[3][16:0]};
      tp = c_part.tex_p;
      tq = c_part.tex_q;
      vrec.part = c_part;
      if (mode_flags_ff[0]) begin
         vrec.tex_u = {tq, bqe_pkg::TEX_ONE - tp, bqe_pkg::TEX_ONE - tq, tp};
         vrec.tex_v = {bqe_pkg::TEX_ONE - tp, bqe_pkg::TEX_ONE - tq, tp, tq};
      end else begin
         vrec.tex_u = {u1, u1, u0, u0};
         vrec.tex_v = {vb, vt, vt, vb};
      end
   end

   bqe_expand u_expand (
      .clock    (clock),
      .reset    (reset),
      .in_valid (c_valid),
      .in_rec   (vrec),
      .take     (take),
      .rsp      (rsp)
   );

endmodule

// ===== rtl/core/bqe_div_pipe.sv =====
// ----------------------------------------------------------------------------
// bqe_div_pipe
// pipelined restoring divider, one quotient bit per stage, several lanes
// ----------------------------------------------------------------------------
module bqe_div_pipe #(
   parameter int NW    = 32,
   parameter int DW    = 18,
   parameter int LANES = 1,
   parameter int PW    = 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       adv,
   input  logic                       in_valid,
   input  logic [LANES-1:0][NW-1:0]   num,
   input  logic [LANES-1:0][DW-1:0]   den,
   input  logic [PW-1:0]              in_data,
   output logic                       out_valid,
   output logic [LANES-1:0][NW-1:0]   quo,
   output logic [LANES-1:0][DW-1:0]   rem,
   output logic [PW-1:0]              out_data
);

   logic          vld_ff  [NW];
   logic [PW-1:0] data_ff [NW];
   logic [NW-1:0] nq_ff   [NW][LANES];
   logic [DW-1:0] rem_ff  [NW][LANES];

   for (genvar s = 0; s < NW; s++) begin : g_stage
      if (s == 0) begin : g_first
         always_ff @(posedge clock) begin
            if (reset) begin
               vld_ff[s] <= 1'b0;
            end else if (adv) begin
               vld_ff[s] <= in_valid;
            end
         end
         always_ff @(posedge clock) begin
            if (adv) begin
               data_ff[s] <= in_data;
            end
         end
      end else begin : g_rest
         always_ff @(posedge clock) begin
            if (reset) begin
               vld_ff[s] <= 1'b0;
            end else if (adv) begin
               vld_ff[s] <= vld_ff[s-1];
            end
         end
         always_ff @(posedge clock) begin
            if (adv) begin
               data_ff[s] <= data_ff[s-1];
            end
         end
      end

      for (genvar l = 0; l < LANES; l++) begin : g_lane
         logic [NW-1:0] nq_prev;
         logic [DW-1:0] rem_prev;
         logic [DW:0]   trial;
         logic [DW:0]   diff;
         logic          take;

         if (s == 0) begin : g_src_in
            assign nq_prev  = num[l];
            assign rem_prev = '0;
         end else begin : g_src_ff
            assign nq_prev  = nq_ff[s-1][l];
            assign rem_prev = rem_ff[s-1][l];
         end

         assign trial = {rem_prev, nq_prev[NW-1]};
         assign take  = (trial >= {1'b0, den[l]});
         assign diff  = trial - {1'b0, den[l]};

         always_ff @(posedge clock) begin
            if (adv) begin
               nq_ff[s][l]  <= {nq_prev[NW-2:0], take};
               rem_ff[s][l] <= take ? diff[DW-1:0] : trial[DW-1:0];
            end
         end
      end
   end

   for (genvar l = 0; l < LANES; l++) begin : g_out
      assign quo[l] = nq_ff[NW-1][l];
      assign rem[l] = rem_ff[NW-1][l];
   end

   assign out_valid = vld_ff[NW-1];
   assign out_data  = data_ff[NW-1];

endmodule

// ===== rtl/core/bqe_front.sv =====
// ----------------------------------------------------------------------------
// bqe_front
// five stage front end: vector scaling, colour, frame product, sine/cosine
// ----------------------------------------------------------------------------
module bqe_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   adv,
   bqe_req_if.sink                req,
   input  logic [47:0]            camera_left,
   input  logic [47:0]            camera_up,
   input  logic [31:0]            frame_rate,
   input  logic [63:0]            tint_color,
   input  logic [1:0]             mode_flags,
   output logic                   out_valid,
   output bqe_pkg::particle_type  out_part,
   output logic [31:0]            out_frame
);

   logic [4:0]                   vld_ff;
   bqe_pkg::particle_type        part_ff  [4];
   logic [31:0]                  frame_ff [4];
   logic [1:0][14:0]             x_ff     [3];
   logic [1:0]                   neg_ff   [3];
   logic [1:0][15:0]             x2_ff    [2];
   logic [1:0][15:0]             inner_ff;
   logic [1:0][16:0]             mid_ff;
   logic [1:0][18:0]             sv_ff;
   bqe_pkg::particle_type        out_ff;
   logic [31:0]                  out_frame_ff;

   bqe_pkg::particle_type        part_in;
   logic [63:0]                  frame_prod;
   logic [1:0][15:0]             ang;
   logic [1:0][14:0]             x_in;
   logic [1:0][29:0]             xx;
   logic [2:0][32:0]             lprod;
   logic [2:0][32:0]             uprod;
   logic [3:0][32:0]             cprod;
   logic [1:0][28:0]             t1p;
   logic [1:0][31:0]             t2p;
   logic [1:0][31:0]             rp;
   logic [1:0][18:0]             sv_in;
   logic signed [19:0]           dsub;
   logic signed [19:0]           dadd;
   logic signed [19:0]           p_full;
   logic signed [19:0]           q_full;

   assign ang[0] = req.rotation;
   assign ang[1] = req.rotation + bqe_pkg::QUARTER_TURN;

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         x_in[l] = bqe_pkg::sine_arg(ang[l]);
         xx[l]   = x_in[l] * x_in[l];
         t1p[l]  = x2_ff[0][l] * bqe_pkg::SIN_C;
         t2p[l]  = x2_ff[1][l] * inner_ff[l];
         rp[l]   = x_ff[2][l] * mid_ff[l];
         sv_in[l] = neg_ff[2][l] ? (19'd0 - {1'b0, rp[l][31:14]}) : {1'b0, rp[l][31:14]};
      end
      for (int i = 0; i < 3; i++) begin
         lprod[i] = $signed(camera_left[16*i +: 16]) * $signed({1'b0, req.half_size})
                    + 33'sd32;
         uprod[i] = $signed(camera_up[16*i +: 16]) * $signed({1'b0, req.half_size})
                    + 33'sd32;
      end
      cprod[0] = req.color_r * ({1'b0, tint_color[15:0]}  + 17'd1);
      cprod[1] = req.color_g * ({1'b0, tint_color[31:16]} + 17'd1);
      cprod[2] = req.color_b * ({1'b0, tint_color[47:32]} + 17'd1);
      cprod[3] = req.color_a * ({1'b0, tint_color[63:48]} + 17'd1);
      frame_prod = req.life_time * frame_rate;

      part_in = '0;
      part_in.pos_x = req.pos_x;
      part_in.pos_y = req.pos_y;
      part_in.pos_z = req.pos_z;
      part_in.lv_x  = lprod[0][32:6];
      part_in.lv_y  = lprod[1][32:6];
      part_in.lv_z  = lprod[2][32:6];
      part_in.uv_x  = uprod[0][32:6];
      part_in.uv_y  = uprod[1][32:6];
      part_in.uv_z  = uprod[2][32:6];
      part_in.col_r = mode_flags[1] ? cprod[0][31:16] : tint_color[15:0];
      part_in.col_g = mode_flags[1] ? cprod[1][31:16] : tint_color[31:16];
      part_in.col_b = mode_flags[1] ? cprod[2][31:16] : tint_color[47:32];
      part_in.col_a = mode_flags[1] ? cprod[3][31:16] : tint_color[63:48];
      part_in.batch_end = req.batch_end;

      // sine in lane 0, cosine in lane 1
      dsub   = $signed({sv_ff[1][18], sv_ff[1]}) - $signed({sv_ff[0][18], sv_ff[0]});
      dadd   = $signed({sv_ff[1][18], sv_ff[1]}) + $signed({sv_ff[0][18], sv_ff[0]});
      p_full = bqe_pkg::TEX_HALF + (dsub >>> 1);
      q_full = bqe_pkg::TEX_HALF + (dadd >>> 1);
   end

   assign req.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[3:0], req.valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         part_ff[0]  <= part_in;
         frame_ff[0] <= frame_prod[63:32];
         for (int l = 0; l < 2; l++) begin
            x_ff[0][l]   <= x_in[l];
            neg_ff[0][l] <= ang[l][15];
            x2_ff[0][l]  <= xx[l][29:14];
            inner_ff[l]  <= bqe_pkg::SIN_B - {1'b0, t1p[l][28:14]};
            mid_ff[l]    <= bqe_pkg::SIN_A - t2p[l][30:14];
            sv_ff[l]     <= sv_in[l];
         end
         for (int s = 1; s < 4; s++) begin
            part_ff[s]  <= part_ff[s-1];
            frame_ff[s] <= frame_ff[s-1];
         end
         for (int s = 1; s < 3; s++) begin
            x_ff[s]   <= x_ff[s-1];
            neg_ff[s] <= neg_ff[s-1];
         end
         x2_ff[1] <= x2_ff[0];
         out_ff       <= part_ff[3];
         out_ff.tex_p <= p_full[17:0];
         out_ff.tex_q <= q_full[17:0];
         out_frame_ff <= frame_ff[3];
      end
   end

   assign out_valid = vld_ff[4];
   assign out_part  = out_ff;
   assign out_frame = out_frame_ff;

endmodule

// ===== rtl/core/bqe_expand.sv =====
// ----------------------------------------------------------------------------
// bqe_expand
// holds one particle and emits its four corner vertices, one per cycle while rsp is ready
// ----------------------------------------------------------------------------
`include "billboard_quad_expander_core_assert.svh"

module bqe_expand (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  bqe_pkg::vertex_type  in_rec,
   output logic                 take,
   bqe_rsp_if.source            rsp
);

   bqe_pkg::vertex_type  rec_ff;
   logic                 rec_valid_ff;
   logic [1:0]           cnt_ff;
   logic                 out_valid_ff;
   logic signed [31:0]   vx_ff, vy_ff, vz_ff;
   logic [17:0]          tu_ff, tv_ff;
   logic [15:0]          r_ff, g_ff, b_ff, a_ff;
   logic                 last_ff, done_ff;

   logic                 load_out;
   logic                 emit;
   logic                 last;
   logic signed [33:0]   sx, sy, sz;
   logic signed [33:0]   lx, ly, lz, ux, uy, uz;

   assign load_out = !out_valid_ff || rsp.ready;
   assign emit     = load_out && rec_valid_ff;
   assign last     = (cnt_ff == 2'd3);
   assign take     = !rec_valid_ff || (emit && last);

   always_comb begin
      lx = 34'(rec_ff.part.lv_x);
      ly = 34'(rec_ff.part.lv_y);
      lz = 34'(rec_ff.part.lv_z);
      ux = 34'(rec_ff.part.uv_x);
      uy = 34'(rec_ff.part.uv_y);
      uz = 34'(rec_ff.part.uv_z);
      // left negative on the first two corners, up negative on first and last
      if (!cnt_ff[1]) begin
         lx = -lx; ly = -ly; lz = -lz;
      end
      if (cnt_ff[0] == cnt_ff[1]) begin
         ux = -ux; uy = -uy; uz = -uz;
      end
      sx = 34'(rec_ff.part.pos_x) + lx + ux;
      sy = 34'(rec_ff.part.pos_y) + ly + uy;
      sz = 34'(rec_ff.part.pos_z) + lz + uz;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rec_valid_ff <= 1'b0;
         cnt_ff       <= 2'd0;
         out_valid_ff <= 1'b0;
      end else begin
         if (load_out) begin
            out_valid_ff <= rec_valid_ff;
         end
         if (take) begin
            rec_valid_ff <= in_valid;
            cnt_ff       <= 2'd0;
         end else if (emit) begin
            cnt_ff <= cnt_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take && in_valid) begin
         rec_ff <= in_rec;
      end
      if (emit) begin
         vx_ff   <= bqe_pkg::sat_pos(sx);
         vy_ff   <= bqe_pkg::sat_pos(sy);
         vz_ff   <= bqe_pkg::sat_pos(sz);
         tu_ff   <= rec_ff.tex_u[cnt_ff];
         tv_ff   <= rec_ff.tex_v[cnt_ff];
         r_ff    <= rec_ff.part.col_r;
         g_ff    <= rec_ff.part.col_g;
         b_ff    <= rec_ff.part.col_b;
         a_ff    <= rec_ff.part.col_a;
         last_ff <= last;
         done_ff <= last && rec_ff.part.batch_end;
      end
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.vert_x     = vx_ff;
   assign rsp.vert_y     = vy_ff;
   assign rsp.vert_z     = vz_ff;
   assign rsp.tex_u      = tu_ff;
   assign rsp.tex_v      = tv_ff;
   assign rsp.out_r      = r_ff;
   assign rsp.out_g      = g_ff;
   assign rsp.out_b      = b_ff;
   assign rsp.out_a      = a_ff;
   assign rsp.quad_last  = last_ff;
   assign rsp.batch_done = done_ff;

   `BQE_ASSERT_NEXT(a_load_starts_quad, take && in_valid, rec_valid_ff && cnt_ff == 2'd0)
   `BQE_ASSERT_IMPLY(a_count_needs_rec, cnt_ff != 2'd0, rec_valid_ff)
   `BQE_ASSERT_IMPLY(a_done_on_last, out_valid_ff && done_ff, last_ff)

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for billboard_quad_expander_core: each particle item is
// predicted into four vertex items and every vertex is compared field by field
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

   localparam int LATENCY   = 81;
   localparam int LIMIT     = 400000;
   localparam int STALL_LEN = 300;

   typedef struct {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic [15:0]        half_size;
      logic [31:0]        life_time;
      logic [15:0]        rotation;
      logic [15:0]        color_r;
      logic [15:0]        color_g;
      logic [15:0]        color_b;
      logic [15:0]        color_a;
      logic               batch_end;
   } tb_particle_type;

   typedef struct {
      logic signed [31:0] vert_x;
      logic signed [31:0] vert_y;
      logic signed [31:0] vert_z;
      logic signed [17:0] tex_u;
      logic signed [17:0] tex_v;
      logic [15:0]        out_r;
      logic [15:0]        out_g;
      logic [15:0]        out_b;
      logic [15:0]        out_a;
      logic               quad_last;
      logic               batch_done;
   } tb_vertex_type;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [63:0] csr_wdata;

   bqe_req_if req ();
   bqe_rsp_if rsp ();

   billboard_quad_expander_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .rsp       (rsp),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // shadow copy of the registers
   logic [47:0] cam_left;
   logic [47:0] cam_up;
   logic [8:0]  atlas_cols;
   logic [8:0]  atlas_rows;
   logic [31:0] frame_rate;
   logic [63:0] tint;
   logic [1:0]  mode;

   tb_vertex_type expected_verts[$];
   int      errors;
   int      cycles;
   int      particles_sent;
   int      verts_seen;
   int      rsp_hold;
   bit      quiet;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("%0t timeout with %0d vertices outstanding", $time, expected_verts.size());
         $display("billboard_quad_expander_core: mismatch");
         $finish;
      end
   end

   // receiver side: random stalls, or a long hold-off when asked
   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_hold  = rsp_hold - 1;
         rsp.ready = 1'b0;
      end else begin
         rsp.ready = quiet || ($urandom_range(99) >= 15);
      end
   end

   function automatic longint fx_sine(input logic [15:0] ang);
      longint f, x, x2, inner, mid, r;
      f = longint'(ang[13:0]);
      x = ang[14] ? 16384 - f : f;
      x2 = (x * x) >>> 14;
      inner = 42048 - ((x2 * 4640) >>> 14);
      mid = 102944 - ((x2 * inner) >>> 14);
      r = (x * mid) >>> 14;
      return ang[15] ? -r : r;
   endfunction

   function automatic longint cells(input logic [8:0] v);
      if (v == 0) begin
         return 1;
      end
      if (v > bqe_pkg::ATLAS_MAX) begin
         return bqe_pkg::ATLAS_MAX;
      end
      return longint'(v);
   endfunction

   function automatic logic signed [31:0] clip32(input longint v);
      if (v > 64'sd2147483647) begin
         return 32'sh7FFFFFFF;
      end
      if (v < -64'sd2147483648) begin
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

   task automatic predict_quad(input tb_particle_type p);
      longint  pos[3], lv[3], uv[3], tu[4], tv[4];
      longint  s, c, pp, qq, ncol, nrow, frame, cx, ry, u0, u1, vt, vb;
      longint  ls, us;
      logic [15:0] pc[4];
      logic [15:0] col[4];
      logic [15:0] t;
      tb_vertex_type vx;
      pos[0] = longint'(p.pos_x);
      pos[1] = longint'(p.pos_y);
      pos[2] = longint'(p.pos_z);
      for (int i = 0; i < 3; i++) begin
         lv[i] = (longint'($signed(cam_left[16*i +: 16])) * longint'(p.half_size) + 32) >>> 6;
         uv[i] = (longint'($signed(cam_up[16*i +: 16])) * longint'(p.half_size) + 32) >>> 6;
      end
      if (mode[0]) begin
         s = fx_sine(p.rotation);
         c = fx_sine(p.rotation + 16'd16384);
         pp = 32768 + ((c - s) >>> 1);
         qq = 32768 + ((c + s) >>> 1);
         tu[0] = pp;         tv[0] = qq;
         tu[1] = 65536 - qq; tv[1] = pp;
         tu[2] = 65536 - pp; tv[2] = 65536 - qq;
         tu[3] = qq;         tv[3] = 65536 - pp;
      end else begin
         ncol = cells(atlas_cols);
         nrow = cells(atlas_rows);
         frame = longint'((64'(p.life_time) * 64'(frame_rate)) >> 32) % (ncol * nrow);
         cx = frame % ncol;
         ry = frame / ncol;
         u0 = (cx * 65536) / ncol;
         u1 = ((cx + 1) * 65536) / ncol;
         vt = 65536 - (ry * 65536) / nrow;
         vb = 65536 - ((ry + 1) * 65536) / nrow;
         tu[0] = u0; tv[0] = vb;
         tu[1] = u0; tv[1] = vt;
         tu[2] = u1; tv[2] = vt;
         tu[3] = u1; tv[3] = vb;
      end
      pc[0] = p.color_r;
      pc[1] = p.color_g;
      pc[2] = p.color_b;
      pc[3] = p.color_a;
      for (int i = 0; i < 4; i++) begin
         t = tint[16*i +: 16];
         col[i] = mode[1] ? 16'((longint'(pc[i]) * (longint'(t) + 1)) >> 16) : t;
      end
      for (int k = 0; k < 4; k++) begin
         ls = (k < 2) ? -1 : 1;
         us = (k == 0 || k == 3) ? -1 : 1;
         vx.vert_x = clip32(pos[0] + ls * lv[0] + us * uv[0]);
         vx.vert_y = clip32(pos[1] + ls * lv[1] + us * uv[1]);
         vx.vert_z = clip32(pos[2] + ls * lv[2] + us * uv[2]);
         vx.tex_u = tu[k][17:0];
         vx.tex_v = tv[k][17:0];
         vx.out_r = col[0];
         vx.out_g = col[1];
         vx.out_b = col[2];
         vx.out_a = col[3];
         vx.quad_last = (k == 3);
         vx.batch_done = (k == 3) && p.batch_end;
         expected_verts.push_back(vx);
      end
   endtask

   function automatic void check_field(input string name, input longint exp_v,
                                       input longint act_v);
      if (exp_v != act_v) begin
         $display("%0t vertex %0d %s expected %0d actual %0d", $time, verts_seen, name,
                  exp_v, act_v);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      tb_vertex_type e;
      if (!reset && rsp.valid && rsp.ready) begin
         if (expected_verts.size() == 0) begin
            $display("%0t unexpected vertex item x=%0d", $time, rsp.vert_x);
            errors++;
         end else begin
            e = expected_verts.pop_front();
            check_field("vert_x", e.vert_x, rsp.vert_x);
            check_field("vert_y", e.vert_y, rsp.vert_y);
            check_field("vert_z", e.vert_z, rsp.vert_z);
            check_field("tex_u", e.tex_u, rsp.tex_u);
            check_field("tex_v", e.tex_v, rsp.tex_v);
            check_field("out_r", e.out_r, rsp.out_r);
            check_field("out_g", e.out_g, rsp.out_g);
            check_field("out_b", e.out_b, rsp.out_b);
            check_field("out_a", e.out_a, rsp.out_a);
            check_field("quad_last", e.quad_last, rsp.quad_last);
            check_field("batch_done", e.batch_done, rsp.batch_done);
         end
         verts_seen++;
      end
   end

   // called at a falling edge, returns at a falling edge
   task automatic send_particle(input tb_particle_type p);
      if (!quiet) begin
         while ($urandom_range(99) < 15) begin
            @(negedge clock);
         end
      end
      req.pos_x     = p.pos_x;
      req.pos_y     = p.pos_y;
      req.pos_z     = p.pos_z;
      req.half_size = p.half_size;
      req.life_time = p.life_time;
      req.rotation  = p.rotation;
      req.color_r   = p.color_r;
      req.color_g   = p.color_g;
      req.color_b   = p.color_b;
      req.color_a   = p.color_a;
      req.batch_end = p.batch_end;
      req.valid     = 1'b1;
      do begin
         @(posedge clock);
      end while (!req.ready);
      predict_quad(p);
      particles_sent++;
      @(negedge clock);
      req.valid = 1'b0;
   endtask

   task automatic drain();
      wait (expected_verts.size() == 0);
      repeat (LATENCY + 10) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [63:0] data);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      case (idx)
         bqe_pkg::CSR_CAMERA_LEFT: cam_left = data[47:0];
         bqe_pkg::CSR_CAMERA_UP:   cam_up = data[47:0];
         bqe_pkg::CSR_ATLAS_COLS:  atlas_cols = data[8:0];
         bqe_pkg::CSR_ATLAS_ROWS:  atlas_rows = data[8:0];
         bqe_pkg::CSR_FRAME_RATE:  frame_rate = data[31:0];
         bqe_pkg::CSR_TINT_COLOR:  tint = data;
         bqe_pkg::CSR_MODE_FLAGS:  mode = data[1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   function automatic tb_particle_type rand_particle();
      tb_particle_type p;
      p.pos_x     = $urandom;
      p.pos_y     = $urandom;
      p.pos_z     = $urandom;
      p.half_size = $urandom_range(65535);
      p.life_time = $urandom;
      p.rotation  = $urandom_range(65535);
      p.color_r   = $urandom_range(65535);
      p.color_g   = $urandom_range(65535);
      p.color_b   = $urandom_range(65535);
      p.color_a   = $urandom_range(65535);
      p.batch_end = $urandom_range(1);
      if ($urandom_range(3) == 0) begin
         p.pos_x = $signed(16'($urandom)) <<< 16;
         p.life_time = $urandom_range(1 << 20);
      end
      return p;
   endfunction

   function automatic tb_particle_type make_particle(input logic [31:0] pos,
                                                     input logic [15:0] hs,
                                                     input logic [31:0] life,
                                                     input logic [15:0] rot,
                                                     input logic [15:0] colv,
                                                     input logic last);
      tb_particle_type p;
      p.pos_x = pos;
      p.pos_y = ~pos;
      p.pos_z = pos ^ 32'h00FF_FF00;
      p.half_size = hs;
      p.life_time = life;
      p.rotation = rot;
      p.color_r = colv;
      p.color_g = ~colv;
      p.color_b = colv ^ 16'h5A5A;
      p.color_a = colv;
      p.batch_end = last;
      return p;
   endfunction

   task automatic test_reset_defaults();
      send_particle(make_particle(32'h0001_0000, 16'h0100, 32'h0000_8000, 16'd0, 16'h8000, 1));
      send_particle(make_particle(32'h8000_0000, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'h0, 0));
      drain();
   endtask

   task automatic test_extremes();
      csr_write(bqe_pkg::CSR_CAMERA_LEFT, 64'h0000_8000_7FFF_8000);
      csr_write(bqe_pkg::CSR_CAMERA_UP, 64'h0000_7FFF_8000_7FFF);
      csr_write(bqe_pkg::CSR_TINT_COLOR, 64'h0);
      send_particle(make_particle(32'h7FFF_FFFF, 16'hFFFF, 32'd0, 16'd0, 16'hFFFF, 0));
      send_particle(make_particle(32'h8000_0000, 16'hFFFF, 32'd0, 16'd0, 16'h0000, 1));
      send_particle(make_particle(32'h0, 16'h0, 32'd0, 16'd0, 16'h1234, 0));
      send_particle(make_particle(32'h7FFF_0000, 16'h8000, 32'd0, 16'd0, 16'hFFFF, 1));
      drain();
   endtask

   task automatic test_atlas();
      logic [15:0] sz[5] = '{16'd0, 16'd1, 16'd4, 16'd256, 16'd257};
      csr_write(bqe_pkg::CSR_TINT_COLOR, 64'hFFFF_FFFF_FFFF_FFFF);
      csr_write(bqe_pkg::CSR_FRAME_RATE, 32'hFFFF_FFFF);
      for (int i = 0; i < 5; i++) begin
         csr_write(bqe_pkg::CSR_ATLAS_COLS, (i == 4) ? 9'h1FF : sz[i]);
         csr_write(bqe_pkg::CSR_ATLAS_ROWS, sz[4 - i]);
         send_particle(make_particle($urandom, 16'h0100, 32'hFFFF_FFFF, 16'd0, 16'h0F0F, 0));
         send_particle(make_particle($urandom, 16'h0100, 32'h0003_4000, 16'd0, 16'hF0F0, 1));
         drain();
      end
      csr_write(bqe_pkg::CSR_FRAME_RATE, 32'h0);
      send_particle(make_particle(32'h0, 16'h0040, 32'hFFFF_FFFF, 16'd0, 16'h0, 1));
      drain();
   endtask

   task automatic test_rotated();
      logic [15:0] angles[7] = '{16'd0, 16'd8192, 16'd16384, 16'd32768, 16'd49152,
                                 16'd16383, 16'hFFFF};
      csr_write(bqe_pkg::CSR_MODE_FLAGS, 2'b01);
      foreach (angles[i]) begin
         send_particle(make_particle($urandom, $urandom_range(65535), $urandom, angles[i],
                                     16'hC3C3, i[0]));
      end
      drain();
   endtask

   task automatic test_colored();
      csr_write(bqe_pkg::CSR_MODE_FLAGS, 2'b10);
      csr_write(bqe_pkg::CSR_TINT_COLOR, 64'hFFFF_0000_8000_7FFF);
      send_particle(make_particle(32'h1, 16'h10, 32'h2_0000, 16'd0, 16'hFFFF, 0));
      send_particle(make_particle(32'h1, 16'h10, 32'h2_0000, 16'd0, 16'h0001, 1));
      drain();
      csr_write(bqe_pkg::CSR_MODE_FLAGS, 2'b11);
      send_particle(make_particle(32'h1, 16'h10, 32'h2_0000, 16'd12345, 16'h8000, 1));
      drain();
   endtask

   task automatic random_config();
      csr_write(bqe_pkg::CSR_CAMERA_LEFT, {$urandom, $urandom});
      csr_write(bqe_pkg::CSR_CAMERA_UP, {$urandom, $urandom});
      csr_write(bqe_pkg::CSR_ATLAS_COLS, ($urandom_range(7) == 0) ? $urandom_range(511)
                                                                  : $urandom_range(1, 16));
      csr_write(bqe_pkg::CSR_ATLAS_ROWS, ($urandom_range(7) == 0) ? $urandom_range(511)
                                                                  : $urandom_range(1, 16));
      csr_write(bqe_pkg::CSR_FRAME_RATE,
                ($urandom_range(1) == 0) ? $urandom : $urandom_range(1 << 20));
      csr_write(bqe_pkg::CSR_TINT_COLOR, {$urandom, $urandom});
      csr_write(bqe_pkg::CSR_MODE_FLAGS, $urandom_range(3));
   endtask

   task automatic test_random();
      for (int phase = 0; phase < 2; phase++) begin
         random_config();
         quiet = (phase == 1);
         repeat (6) send_particle(rand_particle());
         quiet = 1'b0;
         drain();
      end
   endtask

   // enough items to fill every pipeline stage and stall the input
   task automatic test_backpressure();
      random_config();
      quiet = 1'b1;
      rsp_hold = STALL_LEN;
      repeat (90) send_particle(rand_particle());
      quiet = 1'b0;
      drain();
   endtask

   initial begin
      errors = 0;
      cycles = 0;
      particles_sent = 0;
      verts_seen = 0;
      rsp_hold = 0;
      quiet = 1'b0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req.valid = 1'b0;
      req.pos_x = '0;
      req.pos_y = '0;
      req.pos_z = '0;
      req.half_size = '0;
      req.life_time = '0;
      req.rotation = '0;
      req.color_r = '0;
      req.color_g = '0;
      req.color_b = '0;
      req.color_a = '0;
      req.batch_end = 1'b0;
      rsp.ready = 1'b0;
      cam_left = '0;
      cam_up = '0;
      atlas_cols = 9'd1;
      atlas_rows = 9'd1;
      frame_rate = 32'd65536;
      tint = '1;
      mode = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_defaults();
      test_extremes();
      test_atlas();
      test_rotated();
      test_colored();
      test_random();
      test_backpressure();

      $display("covered %0d particles and %0d vertices over atlas, rotated and colored modes,",
               particles_sent, verts_seen);
      $display("register extremes, out-of-range atlas sizes and a long output stall");
      if (errors == 0) begin
         $display("billboard_quad_expander_core: match");
      end else begin
         $display("billboard_quad_expander_core: mismatch");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/bqe_pkg.sv
rtl/core/bqe_req_if.sv
rtl/core/bqe_rsp_if.sv
rtl/core/bqe_div_pipe.sv
rtl/core/bqe_front.sv
rtl/core/bqe_expand.sv
rtl/core/billboard_quad_expander_core.sv
verif/tb_top.sv
